// File: rtl/ble_pkg.sv
`default_nettype none

package ble_pkg;

  // Sequencer states of the estimator
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIM,
    ST_MEAN,
    ST_SEARCH,
    ST_INTERP,
    ST_FIN
  } state_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_DROP  = 2'd0,
    CFG_TOLERANCE = 2'd1,
    CFG_REQ_CONF  = 2'd2
  } cfg_idx_e;

  localparam int unsigned CURVE_POINTS = 12;
  localparam int unsigned CURVE_IDX_W  = 4;
  localparam int unsigned DEN_W        = 8;   // holds every curve span and the trim count
  localparam int unsigned PCT_W        = 7;
  localparam int unsigned MV_W         = 16;
  localparam int unsigned CONF_W       = 4;

  localparam logic [CURVE_IDX_W-1:0] CURVE_LAST = CURVE_IDX_W'(CURVE_POINTS - 1);
  localparam logic [PCT_W-1:0]       PCT_FULL   = 7'd100;
  localparam logic [CONF_W-1:0]      CONF_MAX   = 4'd15;

  typedef logic [CURVE_IDX_W-1:0] curve_idx_t;

  // Discharge curve, highest voltage first
  function automatic logic [MV_W-1:0] curve_mv(curve_idx_t idx);
    logic [MV_W-1:0] mv;
    case (idx)
      4'd0:    mv = 16'd4200;
      4'd1:    mv = 16'd4100;
      4'd2:    mv = 16'd4000;
      4'd3:    mv = 16'd3920;
      4'd4:    mv = 16'd3850;
      4'd5:    mv = 16'd3790;
      4'd6:    mv = 16'd3750;
      4'd7:    mv = 16'd3700;
      4'd8:    mv = 16'd3630;
      4'd9:    mv = 16'd3550;
      4'd10:   mv = 16'd3400;
      4'd11:   mv = 16'd3300;
      default: mv = 16'd3300;
    endcase
    return mv;
  endfunction

  function automatic logic [PCT_W-1:0] curve_pct(curve_idx_t idx);
    logic [PCT_W-1:0] pct;
    case (idx)
      4'd0:    pct = 7'd100;
      4'd1:    pct = 7'd90;
      4'd2:    pct = 7'd80;
      4'd3:    pct = 7'd70;
      4'd4:    pct = 7'd60;
      4'd5:    pct = 7'd50;
      4'd6:    pct = 7'd40;
      4'd7:    pct = 7'd30;
      4'd8:    pct = 7'd20;
      4'd9:    pct = 7'd10;
      4'd10:   pct = 7'd5;
      4'd11:   pct = 7'd0;
      default: pct = 7'd0;
    endcase
    return pct;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ble_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ble_div #(
  parameter int unsigned NUM_W = 20,
  parameter int unsigned DEN_W = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      // quotient bits shift in behind the dividend
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

// File: rtl/battery_level_estimator_top.sv
`default_nettype none

// Battery level estimator.
// Input channel (in_valid_i/in_ready_o, sample_mv_i) takes one voltage sample
// per item. Every SAMPLE_COUNT samples form a group; the group's trimmed mean
// (min and max dropped, rounded average) is mapped onto the discharge curve and
// passed through the drop stabilizer. One result item per group leaves on the
// output channel (out_valid_o/out_ready_i); samples that do not close a group
// give no result.
// The closing sample is followed by the trim, the mean by reciprocal
// multiply, the curve search over up to 12 curve points, the interpolation
// division (only inside the curve, SUM_W = 16 + clog2(SAMPLE_COUNT) quotient
// bits) and the final state. The divider produces one quotient bit per
// cycle. in_ready_o is low while the result is computed.
// The result sits in an output register; further samples are taken while it
// waits. A stalled receiver only holds the sequencer when the next group is
// finished before the previous result has left.
// Reset clears the group, the stabilizer history and loads the register
// defaults (drop 15, tolerance 5, confirmations 2). Config writes (cfg_we_i,
// cfg_idx_i, cfg_data_i) take effect at once; write only while idle.
module battery_level_estimator_top #(
  parameter int unsigned SAMPLE_COUNT = 5
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [1:0]               cfg_idx_i,
  input  wire logic [6:0]               cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [ble_pkg::MV_W-1:0] sample_mv_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [ble_pkg::MV_W-1:0]      voltage_mv_o,
  output logic [ble_pkg::PCT_W-1:0]     measured_percent_o,
  output logic [ble_pkg::PCT_W-1:0]     stable_percent_out_o,
  output logic                          drop_pending_o
);

  import ble_pkg::*;

  localparam int unsigned SUM_W    = MV_W + $clog2(SAMPLE_COUNT);
  localparam int unsigned CNT_W    = $clog2(SAMPLE_COUNT);
  localparam int unsigned HALF     = (SAMPLE_COUNT - 2) / 2;
  localparam int unsigned TRIM_CNT = SAMPLE_COUNT - 2;
  localparam int unsigned PROD_W   = 2 * SUM_W + 1;

  // mean = (trimmed sum * RECIP) >> RECIP_SH, exact for any SUM_W-bit sum
  localparam int unsigned     RECIP_SH = SUM_W + $clog2(TRIM_CNT);
  localparam logic [SUM_W:0]  RECIP    = (SUM_W + 1)'(((64'd1 << RECIP_SH) +
                                         64'(TRIM_CNT) - 64'd1) / 64'(TRIM_CNT));

  state_e state_q, state_d;

  // configuration
  logic [PCT_W-1:0]  max_drop_q;
  logic [PCT_W-1:0]  tol_q;
  logic [CONF_W-1:0] req_conf_q;

  // group accumulation
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  sum_q;
  logic [MV_W-1:0]   min_q;
  logic [MV_W-1:0]   max_q;

  // per-group working values
  logic [SUM_W-1:0]  trim_q;
  logic [MV_W-1:0]   mv_q;
  curve_idx_t        idx_q;
  logic [PCT_W-1:0]  pct_q;

  // stabilizer history
  logic              hv_q;
  logic [PCT_W-1:0]  stable_q;
  logic [PCT_W-1:0]  pend_q;
  logic [CONF_W-1:0] pcnt_q;

  // result register
  logic              out_valid_q;
  logic [MV_W-1:0]   out_mv_q;
  logic [PCT_W-1:0]  out_meas_q;
  logic [PCT_W-1:0]  out_stable_q;
  logic              out_pend_q;

  logic              in_acc;
  logic              last_sample;
  logic              div_start;
  logic [SUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [SUM_W-1:0]  div_quot;
  logic              mv_ge;
  logic              fin_go;

  // interpolation terms for the current curve segment
  logic [MV_W-1:0]   seg_span16;
  logic [MV_W-1:0]   seg_off16;
  logic [PCT_W-1:0]  seg_rise7;
  logic [11:0]       seg_prod;
  logic [SUM_W-1:0]  interp_num;
  logic [SUM_W-1:0]  trim_num;
  logic [PROD_W-1:0] mean_prod;

  assign in_acc      = in_valid_i && in_ready_o;
  assign last_sample = (cnt_q == CNT_W'(SAMPLE_COUNT - 1));
  assign mv_ge       = (mv_q >= curve_mv(idx_q));
  assign fin_go      = !out_valid_q || out_ready_i;

  assign seg_span16 = curve_mv(idx_q - 1'b1) - curve_mv(idx_q);
  assign seg_off16  = mv_q - curve_mv(idx_q);
  assign seg_rise7  = curve_pct(idx_q - 1'b1) - curve_pct(idx_q);
  assign seg_prod   = seg_off16[7:0] * seg_rise7[3:0];
  assign interp_num = SUM_W'(seg_prod) + SUM_W'(seg_span16[7:1]);
  assign trim_num   = sum_q - SUM_W'(min_q) - SUM_W'(max_q) + SUM_W'(HALF);
  assign mean_prod  = PROD_W'(trim_q) * PROD_W'(RECIP);

  assign div_num = interp_num;
  assign div_den = seg_span16[DEN_W-1:0];

  ble_div #(
    .NUM_W (SUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc && last_sample) state_d = ST_TRIM;
      ST_TRIM:   state_d = ST_MEAN;
      ST_MEAN:   state_d = ST_SEARCH;
      ST_SEARCH: begin
        if (mv_ge) begin
          state_d = (idx_q == '0) ? ST_FIN : ST_INTERP;
        end else if (idx_q == CURVE_LAST) begin
          state_d = ST_FIN;
        end
      end
      ST_INTERP: if (div_done) state_d = ST_FIN;
      ST_FIN:    if (fin_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SEARCH: div_start  = mv_ge && (idx_q != '0);
      ST_TRIM, ST_MEAN, ST_INTERP, ST_FIN: ;
      default: ;
    endcase
  end

  // stabilizer decision for pct_q
  logic              drop_ok;
  logic [PCT_W-1:0]  pdiff;
  logic [PCT_W-1:0]  stab_pend;
  logic [CONF_W-1:0] stab_cnt;
  logic              stab_take;

  always_comb begin
    drop_ok   = !hv_q || (pct_q >= stable_q) || ((stable_q - pct_q) <= max_drop_q);
    pdiff     = (pend_q > pct_q) ? (pend_q - pct_q) : (pct_q - pend_q);
    stab_pend = pend_q;
    stab_cnt  = pcnt_q;
    if ((pcnt_q != '0) && (pdiff <= tol_q)) begin
      if (pcnt_q < CONF_MAX) stab_cnt = pcnt_q + 1'b1;
    end else begin
      stab_pend = pct_q;
      stab_cnt  = CONF_W'(1);
    end
    stab_take = drop_ok || (stab_cnt >= req_conf_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      max_drop_q <= 7'd15;
      tol_q      <= 7'd5;
      req_conf_q <= 4'd2;
      cnt_q      <= '0;
      hv_q       <= 1'b0;
      stable_q   <= '0;
      pend_q     <= '0;
      pcnt_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_DROP:  max_drop_q <= cfg_data_i;
          CFG_TOLERANCE: tol_q      <= cfg_data_i;
          CFG_REQ_CONF:  req_conf_q <= cfg_data_i[CONF_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) cnt_q <= last_sample ? '0 : cnt_q + 1'b1;

      if (state_q == ST_FIN && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (state_q == ST_FIN && fin_go) begin
        if (stab_take) begin
          hv_q     <= 1'b1;
          stable_q <= pct_q;
          pend_q   <= '0;
          pcnt_q   <= '0;
        end else begin
          pend_q <= stab_pend;
          pcnt_q <= stab_cnt;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (cnt_q == '0) begin
        sum_q <= SUM_W'(sample_mv_i);
        min_q <= sample_mv_i;
        max_q <= sample_mv_i;
      end else begin
        sum_q <= sum_q + SUM_W'(sample_mv_i);
        if (sample_mv_i < min_q) min_q <= sample_mv_i;
        if (sample_mv_i > max_q) max_q <= sample_mv_i;
      end
    end

    case (state_q)
      ST_TRIM: begin
        trim_q <= trim_num;
      end
      ST_MEAN: begin
        mv_q  <= mean_prod[RECIP_SH +: MV_W];
        idx_q <= '0;
      end
      ST_SEARCH: begin
        if (mv_ge && idx_q == '0) begin
          pct_q <= PCT_FULL;
        end else if (!mv_ge && idx_q == CURVE_LAST) begin
          pct_q <= '0;
        end else if (!mv_ge) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      ST_INTERP: begin
        if (div_done) pct_q <= curve_pct(idx_q) + div_quot[PCT_W-1:0];
      end
      ST_FIN: begin
        if (fin_go) begin
          out_mv_q     <= mv_q;
          out_meas_q   <= pct_q;
          out_stable_q <= stab_take ? pct_q : stable_q;
          out_pend_q   <= !stab_take;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o          = out_valid_q;
  assign voltage_mv_o         = out_mv_q;
  assign measured_percent_o   = out_meas_q;
  assign stable_percent_out_o = out_stable_q;
  assign drop_pending_o       = out_pend_q;

  // divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_INTERP))
    else $error("divider done outside a wait state");

  // a new result only comes from the final state
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside final state");

  // pending flag of the shown result tracks the confirmation counter
  a_pend_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_pend_q == (pcnt_q != '0)))
    else $error("drop pending flag out of step with counter");

  // percentages stay on the curve range
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_meas_q <= PCT_FULL && out_stable_q <= PCT_FULL))
    else $error("percentage above full scale");

  // no sample taken in the mean and interpolation states
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MEAN || state_q == ST_INTERP) |-> !in_ready_o)
    else $error("sample accepted while busy");

endmodule

`default_nettype wire
